// File: rtl/bzs_pkg.sv
package bzs_pkg;

   // Field widths.
   localparam int COORD_W = 16;
   localparam int FRAC_W  = 4;
   localparam int CTRL_W  = COORD_W + FRAC_W;

   // The parameter t is Q0.16. The running value needs one more bit to hold t = 1.
   localparam int T_W    = 16;
   localparam int TACC_W = T_W + 1;

   localparam logic [T_W-1:0]    MIN_STEP = T_W'(1041);
   localparam logic [T_W-1:0]    STEP_RST = T_W'(4096);
   localparam logic [TACC_W-1:0] ONE_T    = TACC_W'(1) << T_W;

   // Widths of the forward difference terms.
   // K = 16a + 16c - 2b and M = b - 16a, both in units of the control point LSB.
   localparam int K_W     = CTRL_W + 3;
   localparam int M_W     = CTRL_W + 2;
   localparam int MA_W    = 2 * T_W + 1;
   localparam int ACC_W   = MA_W + K_W;
   localparam int SHIFT_W = 2 * T_W + FRAC_W;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INCL = CSR_IDX_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SS,
      ST_KX,
      ST_KY,
      ST_MX,
      ST_MY,
      ST_FIN,
      ST_EMIT,
      ST_LAST
   } state_type;

   typedef enum logic [2:0] {
      MSEL_SS,
      MSEL_S2K_X,
      MSEL_S2K_Y,
      MSEL_SM_X,
      MSEL_SM_Y
   } msel_type;

   typedef struct packed {
      logic     load;
      msel_type msel;
      logic     cap_s2;
      logic     cap_kx;
      logic     cap_ky;
      logic     cap_mx;
      logic     cap_my;
      logic     emit;
      logic     emit_last;
   } ctrl_type;

   // Divide by 2^SHIFT_W, truncating toward zero, and keep the coordinate bits.
   function automatic logic [COORD_W-1:0] trunc_coord(input logic [ACC_W-1:0] n);
      logic [COORD_W-1:0] q;
      q = n[SHIFT_W +: COORD_W];
      if (n[ACC_W-1] && (|n[SHIFT_W-1:0])) begin
         q = q + COORD_W'(1);
      end
      return q;
   endfunction

endpackage

// File: rtl/bzs_mul.sv
module bzs_mul (
   input  logic                              clock,
   input  logic signed [bzs_pkg::MA_W-1:0]   op_a,
   input  logic signed [bzs_pkg::K_W-1:0]    op_b,
   output logic signed [bzs_pkg::ACC_W-1:0]  prod_ff
);
   import bzs_pkg::*;

   logic signed [ACC_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/bzs_seq.sv
module bzs_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_free,
   input  logic              more,
   output logic              req_ready,
   output bzs_pkg::ctrl_type ctrl
);
   import bzs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctrl      = '0;
      ctrl.msel = MSEL_SS;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = ST_SS;
            end
         end
         ST_SS: begin
            ctrl.msel = MSEL_SS;
            state_in  = ST_KX;
         end
         ST_KX: begin
            ctrl.cap_s2 = 1'b1;
            ctrl.msel   = MSEL_S2K_X;
            state_in    = ST_KY;
         end
         ST_KY: begin
            ctrl.cap_kx = 1'b1;
            ctrl.msel   = MSEL_S2K_Y;
            state_in    = ST_MX;
         end
         ST_MX: begin
            ctrl.cap_ky = 1'b1;
            ctrl.msel   = MSEL_SM_X;
            state_in    = ST_MY;
         end
         ST_MY: begin
            ctrl.cap_mx = 1'b1;
            ctrl.msel   = MSEL_SM_Y;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            ctrl.cap_my = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               ctrl.emit = 1'b1;
               if (!more) begin
                  state_in = ST_LAST;
               end
            end
         end
         ST_LAST: begin
            if (out_free) begin
               ctrl.emit_last = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/quadratic_bezier_sampler.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | start_x/y, ctrl_x/y, end_x/y
// rsp     | out       | rsp_valid/rsp_ready  | point_x/y, last_point
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A curve goes through these steps, where N is the number of sampled points (at
// most 63): the item is taken in ST_IDLE; in the set-up states ST_SS to ST_FIN the
// shared multiplier forms the forward differences; ST_EMIT gives one point per
// cycle while the output is not stalled, N points in all; ST_LAST gives the final
// endpoint. Reset is synchronous and active high and returns the registers to step
// 4096 with the end sample excluded. A stalled output holds the sequencer in place;
// a new item is taken while the final endpoint still waits in the output register.
module quadratic_bezier_sampler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [bzs_pkg::COORD_W-1:0]   req_start_x,
   input  logic signed [bzs_pkg::COORD_W-1:0]   req_start_y,
   input  logic signed [bzs_pkg::CTRL_W-1:0]    req_ctrl_x,
   input  logic signed [bzs_pkg::CTRL_W-1:0]    req_ctrl_y,
   input  logic signed [bzs_pkg::COORD_W-1:0]   req_end_x,
   input  logic signed [bzs_pkg::COORD_W-1:0]   req_end_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bzs_pkg::COORD_W-1:0]   rsp_point_x,
   output logic signed [bzs_pkg::COORD_W-1:0]   rsp_point_y,
   output logic                                 rsp_last_point,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [bzs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [bzs_pkg::T_W-1:0]       csr_data
);
   import bzs_pkg::*;

   ctrl_type ctrl;

   logic [T_W-1:0]    step_ff;
   logic              incl_ff;
   logic [T_W-1:0]    step_eff;
   logic [TACC_W-1:0] t_ff;
   logic [TACC_W-1:0] t_in;
   logic              more;
   logic              out_free;

   logic signed [K_W-1:0]     kx_ff, ky_ff;
   logic signed [M_W-1:0]     mx_ff, my_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff;
   logic signed [MA_W-1:0]    s2_ff;
   logic signed [ACC_W-1:0]   num_x_ff, num_y_ff;
   logic signed [ACC_W-1:0]   d1_x_ff, d1_y_ff;
   logic signed [ACC_W-1:0]   d2_x_ff, d2_y_ff;

   logic signed [MA_W-1:0]    op_a;
   logic signed [K_W-1:0]     op_b;
   logic signed [ACC_W-1:0]   prod;

   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] point_x_ff, point_y_ff;
   logic                      last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RST;
         incl_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STEP: step_ff <= csr_data;
            CSR_INCL: incl_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign step_eff = (step_ff < MIN_STEP) ? MIN_STEP : step_ff;
   assign t_in     = t_ff + TACC_W'(step_eff);
   assign more     = (t_in < ONE_T) || (incl_ff && (t_in == ONE_T));
   assign out_free = !rsp_valid_ff || rsp_ready;

   bzs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .more      (more),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   always_comb begin
      case (ctrl.msel)
         MSEL_SS: begin
            op_a = {(MA_W-T_W)'(0), step_eff};
            op_b = {(K_W-T_W)'(0), step_eff};
         end
         MSEL_S2K_X: begin
            op_a = prod[MA_W-1:0];
            op_b = kx_ff;
         end
         MSEL_S2K_Y: begin
            op_a = s2_ff;
            op_b = ky_ff;
         end
         MSEL_SM_X: begin
            op_a = {(MA_W-T_W)'(0), step_eff};
            op_b = K_W'(mx_ff);
         end
         MSEL_SM_Y: begin
            op_a = {(MA_W-T_W)'(0), step_eff};
            op_b = K_W'(my_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   bzs_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   // The numerator is a quadratic in the sample index, so it is stepped exactly
   // with a first difference d1 and a constant second difference d2.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         kx_ff    <= (K_W'(req_start_x) <<< FRAC_W) + (K_W'(req_end_x) <<< FRAC_W)
                     - (K_W'(req_ctrl_x) <<< 1);
         ky_ff    <= (K_W'(req_start_y) <<< FRAC_W) + (K_W'(req_end_y) <<< FRAC_W)
                     - (K_W'(req_ctrl_y) <<< 1);
         mx_ff    <= M_W'(req_ctrl_x) - (M_W'(req_start_x) <<< FRAC_W);
         my_ff    <= M_W'(req_ctrl_y) - (M_W'(req_start_y) <<< FRAC_W);
         cx_ff    <= req_end_x;
         cy_ff    <= req_end_y;
         num_x_ff <= {{(ACC_W-SHIFT_W-COORD_W){req_start_x[COORD_W-1]}}, req_start_x,
                      SHIFT_W'(0)};
         num_y_ff <= {{(ACC_W-SHIFT_W-COORD_W){req_start_y[COORD_W-1]}}, req_start_y,
                      SHIFT_W'(0)};
         t_ff     <= '0;
      end
      if (ctrl.cap_s2) begin
         s2_ff <= prod[MA_W-1:0];
      end
      if (ctrl.cap_kx) begin
         d2_x_ff <= prod <<< 1;
         d1_x_ff <= prod;
      end
      if (ctrl.cap_ky) begin
         d2_y_ff <= prod <<< 1;
         d1_y_ff <= prod;
      end
      if (ctrl.cap_mx) begin
         d1_x_ff <= d1_x_ff + (prod <<< (T_W + 1));
      end
      if (ctrl.cap_my) begin
         d1_y_ff <= d1_y_ff + (prod <<< (T_W + 1));
      end
      if (ctrl.emit) begin
         num_x_ff <= num_x_ff + d1_x_ff;
         num_y_ff <= num_y_ff + d1_y_ff;
         d1_x_ff  <= d1_x_ff + d2_x_ff;
         d1_y_ff  <= d1_y_ff + d2_y_ff;
         t_ff     <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit || ctrl.emit_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         point_x_ff <= trunc_coord(num_x_ff);
         point_y_ff <= trunc_coord(num_y_ff);
         last_ff    <= 1'b0;
      end else if (ctrl.emit_last) begin
         point_x_ff <= cx_ff;
         point_y_ff <= cy_ff;
         last_ff    <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = point_x_ff;
   assign rsp_point_y    = point_y_ff;
   assign rsp_last_point = last_ff;

endmodule

// File: rtl/bzs_chk.sv
module bzs_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [bzs_pkg::COORD_W-1:0] rsp_point_x,
   input logic signed [bzs_pkg::COORD_W-1:0] rsp_point_y,
   input logic                               rsp_last_point
);

   // A curve in progress keeps the input closed for the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still ready right after an item was accepted");

   // While the input is open, only the final endpoint of a curve may be pending.
   a_idle_only_last: assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid) |-> rsp_last_point)
      else $error("intermediate point pending while input is ready");

   // The block comes out of reset ready for an item.
   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready)
      else $error("input not ready after reset");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_point_x)
         && $stable(rsp_point_y) && $stable(rsp_last_point)))
      else $error("stalled result changed");

endmodule

bind quadratic_bezier_sampler bzs_chk u_bzs_chk (.*);
